FILE: sv/rmh_pkg.sv
// Package for the running median unit: depth constants, payload structs,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package rmh_pkg;
  localparam int unsigned HEAP_DEPTH = 512;
  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] sample;
    logic               first;
  } rmh_in_t;

  typedef struct packed {
    logic signed [31:0] median;
    logic               overflow;
  } rmh_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch input word, apply first flag
    OP_DECIDE,   // choose path, set heap select and sift value
    OP_PUSH_INIT,
    OP_PUSH_RD,
    OP_PUSH_STEP,
    OP_REP_RD,
    OP_REP_CMP,
    OP_REP_STEP,
    OP_WR_HOLE,
    OP_TOP_RD,
    OP_FINISH,
    OP_DROP      // word dropped on a full heap: flag overflow, hold phase
  } rmh_op_t;

  typedef struct packed {
    rmh_op_t op;
  } rmh_cmd_t;

  typedef struct packed {
    logic full;       // target heap full
    logic swap;       // sample crosses the other heap's top
    logic push_done;  // sift-up finished
    logic rep_done;   // sift-down finished
    logic odd;        // current word is odd-numbered
  } rmh_sts_t;
endpackage

FILE: sv/rmh_datapath.sv
// Datapath: two heap memories, counts, sift index and compare logic.
// Depends on rmh_pkg.
`timescale 1ns / 1ps
module rmh_datapath
  import rmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rmh_in_t  in_word,
  input  rmh_cmd_t cmd,
  output rmh_sts_t sts,
  output rmh_out_t res
);
  logic signed [31:0] lo_mem [HEAP_DEPTH];
  logic signed [31:0] up_mem [HEAP_DEPTH];

  logic [CW-1:0] lo_cnt_r, up_cnt_r, lo_cnt_nxt, up_cnt_nxt;
  logic          odd_r, odd_nxt, ovf_r, ovf_nxt;
  logic signed [31:0] s_r, s_nxt, v_r, v_nxt, lo_top_r, up_top_r;
  logic signed [31:0] lo_top_nxt, up_top_nxt;
  logic          hsel_r, hsel_nxt;      // 1: lower (max) heap
  logic          swap_r, swap_nxt, stage2_r, stage2_nxt;
  logic [CW-1:0] i_r, i_nxt, best_r, best_nxt, cnt_sel;
  logic signed [31:0] rd_a_r, rd_b_r;   // registered reads
  logic          we;
  logic          rd_en;
  logic [AW-1:0] wa, ra_a, ra_b;
  logic signed [31:0] wd;
  logic          above_ab, above_va, above_bv;
  logic [CW:0]   l_idx;
  logic          l_in, r_in;
  logic signed [31:0] best_val;

  function automatic logic ranks(input logic mx, input logic signed [31:0] a,
                                 input logic signed [31:0] b);
    ranks = mx ? (a > b) : (a < b);
  endfunction

  assign cnt_sel = hsel_r ? lo_cnt_r : up_cnt_r;
  assign l_idx   = {i_r, 1'b1};
  assign l_in    = (l_idx < {1'b0, cnt_sel});
  assign r_in    = ((l_idx + 1'b1) < {1'b0, cnt_sel});
  assign above_ab = ranks(hsel_r, rd_b_r, rd_a_r);
  assign best_val = (r_in && above_ab) ? rd_b_r : rd_a_r;
  assign above_bv = ranks(hsel_r, best_val, v_r);
  assign above_va = ranks(hsel_r, v_r, rd_a_r);

  // read data is captured only on a read command and held until the next one
  assign rd_en = cmd.op inside {OP_PUSH_RD, OP_REP_RD, OP_TOP_RD};

  // read addresses: parent on push, children on replace, root on top refresh
  always_comb begin
    ra_a = AW'((i_r - 1'b1) >> 1);
    ra_b = ra_a;
    if (cmd.op == OP_REP_RD) begin
      ra_a = AW'(l_idx);
      ra_b = AW'(l_idx + 1'b1);
    end else if (cmd.op == OP_TOP_RD) begin
      ra_a = '0;
      ra_b = '0;
    end
  end

  always_comb begin
    lo_cnt_nxt = lo_cnt_r; up_cnt_nxt = up_cnt_r; odd_nxt = odd_r;
    ovf_nxt = ovf_r; s_nxt = s_r; v_nxt = v_r; hsel_nxt = hsel_r;
    swap_nxt = swap_r; stage2_nxt = stage2_r; i_nxt = i_r; best_nxt = best_r;
    lo_top_nxt = lo_top_r; up_top_nxt = up_top_r;
    we = 1'b0; wa = AW'(i_r); wd = v_r;
    case (cmd.op)
      OP_LOAD: begin
        s_nxt = in_word.sample;
        if (in_word.first) begin
          lo_cnt_nxt = '0; up_cnt_nxt = '0; odd_nxt = 1'b1;
        end
      end
      OP_DECIDE: begin
        stage2_nxt = 1'b0;
        if (odd_r) begin
          swap_nxt = (up_cnt_r != '0) && (s_r > up_top_r);
          hsel_nxt = !swap_nxt;
          v_nxt    = s_r;
        end else begin
          swap_nxt = (lo_cnt_r != '0) && (s_r < lo_top_r);
          hsel_nxt = swap_nxt;
          v_nxt    = s_r;
        end
        if (swap_nxt) i_nxt = '0;
      end
      OP_PUSH_INIT: begin
        // push on the heap that grows: lower when odd
        if (stage2_r || !swap_r) hsel_nxt = odd_r;
        if (stage2_r) v_nxt = odd_r ? up_top_r : lo_top_r;
        i_nxt = odd_r ? lo_cnt_r : up_cnt_r;
        if (odd_r) lo_cnt_nxt = lo_cnt_r + 1'b1;
        else up_cnt_nxt = up_cnt_r + 1'b1;
      end
      OP_PUSH_STEP: begin
        if (above_va) begin
          we = 1'b1; wa = AW'(i_r); wd = rd_a_r;
          i_nxt = (i_r - 1'b1) >> 1;
        end
      end
      OP_REP_CMP: begin
        best_nxt = (r_in && above_ab) ? CW'(l_idx + 1'b1) : CW'(l_idx);
      end
      OP_REP_STEP: begin
        if (above_bv) begin
          we = 1'b1; wa = AW'(i_r); wd = best_val;
          i_nxt = best_r;
        end
      end
      OP_WR_HOLE: begin
        we = 1'b1; wa = AW'(i_r); wd = v_r;
        stage2_nxt = 1'b1;
      end
      OP_FINISH: begin
        odd_nxt = !odd_r;
        lo_top_nxt = rd_a_r;
        up_top_nxt = rd_b_r;
      end
      OP_DROP: begin
        ovf_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // each heap has its own pair of read ports; hsel picks which heap is sifted
  logic signed [31:0] lo_q_a, lo_q_b, up_q_a, up_q_b;
  logic top_rd_r;
  always_ff @(posedge clk) begin
    if (we && hsel_r) lo_mem[wa] <= wd;
    if (we && !hsel_r) up_mem[wa] <= wd;
    if (rd_en) begin
      lo_q_a <= lo_mem[ra_a];
      lo_q_b <= lo_mem[ra_b];
      up_q_a <= up_mem[ra_a];
      up_q_b <= up_mem[ra_b];
    end
  end

  always_comb begin
    if (top_rd_r) begin
      rd_a_r = lo_q_a; rd_b_r = up_q_a;
    end else if (hsel_r) begin
      rd_a_r = lo_q_a; rd_b_r = lo_q_b;
    end else begin
      rd_a_r = up_q_a; rd_b_r = up_q_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_cnt_r <= '0; up_cnt_r <= '0; odd_r <= 1'b1; ovf_r <= 1'b0;
      top_rd_r <= 1'b0;
    end else begin
      lo_cnt_r <= lo_cnt_nxt; up_cnt_r <= up_cnt_nxt;
      odd_r <= odd_nxt; ovf_r <= ovf_nxt;
      if (rd_en) top_rd_r <= (cmd.op == OP_TOP_RD);
    end
    s_r <= s_nxt; v_r <= v_nxt; hsel_r <= hsel_nxt; swap_r <= swap_nxt;
    stage2_r <= stage2_nxt; i_r <= i_nxt; best_r <= best_nxt;
    lo_top_r <= lo_top_nxt; up_top_r <= up_top_nxt;
  end

  assign sts.full      = odd_r ? (lo_cnt_r >= CW'(HEAP_DEPTH))
                               : (up_cnt_r >= CW'(HEAP_DEPTH));
  // once the sift-down hole is written, only the push remains
  assign sts.swap      = swap_r && !stage2_r;
  assign sts.push_done = (i_r == '0) || !above_va;
  assign sts.rep_done  = !l_in || !above_bv;
  assign sts.odd       = odd_r;
  assign res.median    = lo_top_r;
  assign res.overflow  = ovf_r;
endmodule

FILE: sv/rmh_ctrl.sv
// Sequencer for one word: check, decide, optional sift-down, sift-up, top refresh.
// Depends on rmh_pkg.
`timescale 1ns / 1ps
module rmh_ctrl
  import rmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rmh_sts_t sts,
  output rmh_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DEC, S_REP_RD, S_REP_WAIT, S_REP_CMP, S_REP_STEP,
    S_PUSH_INIT, S_PUSH_RD, S_PUSH_WAIT, S_PUSH_STEP, S_WR, S_TOP, S_TOP_W,
    S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_push_r, in_push_nxt;  // hole write closes a sift-up
  logic   emit_r, emit_nxt;
  logic   drop_r, drop_nxt;        // target heap was full at the check

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r; in_push_nxt = in_push_r; emit_nxt = emit_r;
    drop_nxt = drop_r;
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE:  if (in_valid) begin cmd.op = OP_LOAD; state_nxt = S_CHK; end
      S_CHK:   begin
        drop_nxt = sts.full;
        state_nxt = sts.full ? S_TOP : S_DEC;
      end
      S_DEC:   begin
        cmd.op = OP_DECIDE; in_push_nxt = 1'b0; state_nxt = S_PUSH_INIT;
      end
      S_PUSH_INIT: begin
        if (sts.swap && !in_push_r) state_nxt = S_REP_RD;
        else begin cmd.op = OP_PUSH_INIT; in_push_nxt = 1'b1; state_nxt = S_PUSH_RD; end
      end
      S_REP_RD:   begin cmd.op = OP_REP_RD; state_nxt = S_REP_WAIT; end
      S_REP_WAIT: state_nxt = S_REP_CMP;
      S_REP_CMP:  begin
        cmd.op = OP_REP_CMP;
        state_nxt = sts.rep_done ? S_WR : S_REP_STEP;
      end
      S_REP_STEP: begin cmd.op = OP_REP_STEP; state_nxt = S_REP_RD; end
      S_PUSH_RD:   begin cmd.op = OP_PUSH_RD; state_nxt = S_PUSH_WAIT; end
      S_PUSH_WAIT: state_nxt = S_PUSH_STEP;
      S_PUSH_STEP: begin
        if (sts.push_done) state_nxt = S_WR;
        else begin cmd.op = OP_PUSH_STEP; state_nxt = S_PUSH_RD; end
      end
      S_WR: begin
        cmd.op = OP_WR_HOLE;
        state_nxt = in_push_r ? S_TOP : S_PUSH_INIT;
      end
      S_TOP:   begin cmd.op = OP_TOP_RD; state_nxt = S_TOP_W; end
      S_TOP_W: state_nxt = S_FIN;
      S_FIN: begin
        cmd.op = drop_r ? OP_DROP : OP_FINISH;
        emit_nxt = sts.odd && !drop_r;
        state_nxt = S_OUT;
      end
      S_OUT: if (!emit_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = (state_r == S_OUT) && emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; in_push_r <= 1'b0; emit_r <= 1'b0; drop_r <= 1'b0;
    end else begin
      state_r <= state_nxt; in_push_r <= in_push_nxt; emit_r <= emit_nxt;
      drop_r <= drop_nxt;
    end
  end
endmodule

FILE: sv/running_median_two_heaps_unit.sv
// Channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready   | rmh_in_t  (sample, first)
// out     | out | out_valid / out_ready | rmh_out_t (median, overflow)
// One word at a time: after accept, the target heap is checked, the path decided,
// a sift-down run on a swap, then the sift-up and a top refresh follow; a dropped
// word goes straight from the check to the top refresh.
// Reset clears counts, phase and overflow; heap memories are not cleared.
// A result waits in the output register; the next word is taken once read.
// Depends on rmh_pkg, rmh_ctrl, rmh_datapath.
`timescale 1ns / 1ps
module running_median_two_heaps_unit
  import rmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rmh_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rmh_out_t out_data
);
  rmh_cmd_t cmd;
  rmh_sts_t sts;

  rmh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  rmh_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_data), .cmd(cmd), .sts(sts),
    .res(out_data)
  );
endmodule

FILE: sv/rmh_checker.sv
// Port-level checker for the running median unit, bound to the top level.
// Depends on rmh_pkg.
`timescale 1ns / 1ps
module rmh_checker
  import rmh_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input rmh_out_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |=> !out_valid || out_data.overflow)
    else $error("overflow flag cleared");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
endmodule

bind running_median_two_heaps_unit rmh_checker u_rmh_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

FILE: tb/tb_running_median_two_heaps_unit.sv
// Testbench for running_median_two_heaps_unit: drives sample words with random
// idling, predicts lower medians with its own two-heap model, checks results.
// Depends on rmh_pkg and the unit under test.
`timescale 1ns / 1ps
module tb_running_median_two_heaps_unit;
  import rmh_pkg::*;

  int fail_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Tracks the two heaps and queues the expected median words.
  class median_board;
    logic signed [31:0] lo_heap[$];
    logic signed [31:0] hi_heap[$];
    bit odd_phase = 1;
    bit dropped = 0;
    rmh_out_t pending[$];

    // lower heap is max-heap, upper is min-heap; keep sorted queues
    function automatic logic signed [31:0] lo_top();
      return lo_heap[lo_heap.size()-1];
    endfunction

    function automatic void insert_sorted(ref logic signed [31:0] q[$],
                                          input logic signed [31:0] v);
      int i;
      i = 0;
      while (i < q.size() && q[i] <= v) i++;
      q.insert(i, v);
    endfunction

    function automatic void note_word(rmh_in_t w);
      logic signed [31:0] moved;
      rmh_out_t r;
      if (w.first) begin
        lo_heap.delete();
        hi_heap.delete();
        odd_phase = 1;
      end
      if (odd_phase) begin
        if (lo_heap.size() >= HEAP_DEPTH) begin
          dropped = 1;
          return;
        end
        if (hi_heap.size() > 0 && w.sample > hi_heap[0]) begin
          moved = hi_heap.pop_front();
          insert_sorted(hi_heap, w.sample);
          insert_sorted(lo_heap, moved);
        end else begin
          insert_sorted(lo_heap, w.sample);
        end
        odd_phase = 0;
        r.median = lo_top();
        r.overflow = dropped;
        pending.push_back(r);
      end else begin
        if (hi_heap.size() >= HEAP_DEPTH) begin
          dropped = 1;
          return;
        end
        if (lo_heap.size() > 0 && w.sample < lo_top()) begin
          moved = lo_heap.pop_back();
          insert_sorted(lo_heap, w.sample);
          insert_sorted(hi_heap, moved);
        end else begin
          insert_sorted(hi_heap, w.sample);
        end
        odd_phase = 1;
      end
    endfunction

    task automatic check_word(rmh_out_t got);
      rmh_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.median, 32'h0);
        return;
      end
      want = pending.pop_front();
      if (got.median !== want.median) report_mismatch("median", got.median, want.median);
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", {31'b0, got.overflow}, {31'b0, want.overflow});
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  rmh_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  rmh_out_t out_data;

  median_board board = new();
  bit no_idle = 0;
  bit sink_hold = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  running_median_two_heaps_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // accept on sampled handshakes at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_word(in_data);
    if (rst_n && out_valid && out_ready) board.check_word(out_data);
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
    if (quiet_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, or a held stall
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_hold) begin
        out_ready <= 0;
        @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic signed [31:0] s, input bit f);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{sample: s, first: f};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_done();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extremes, ties, swaps in both directions
    send_word(32'sh80000000, 1);
    send_word(32'sh7fffffff, 0);
    send_word(32'sh7fffffff, 0);
    send_word(32'sh80000000, 0);
    send_word(0, 0);
    send_word(-1, 0);
    send_word(5, 0);
    send_word(5, 0);
    send_word(5, 0);
    send_word(100, 1);
    send_word(-100, 0);
    send_word(200, 0);
    send_word(-200, 0);
    send_word(32'sh55555555, 1);
    send_word(32'shaaaaaaaa, 0);
    send_word(32'sh2aaaaaaa, 0);

    // hold the receiver while words keep coming
    sink_hold = 1;
    fork
      begin repeat (300) @(posedge clk); sink_hold = 0; end
      for (k = 0; k < 20; k++) send_word(pick_sample(), 0);
    join
    send_done();
    while (board.pending.size() != 0) @(posedge clk);

    // random streams, mostly short runs restarted by first
    for (k = 0; k < 320; k++) send_word(pick_sample(), $urandom_range(0, 40) == 0);

    // overflow: fill past the heap depth, then keep going
    send_word(pick_sample(), 1);
    for (k = 0; k < 2 * HEAP_DEPTH + 30; k++) send_word(pick_sample(), 0);
    send_word(7, 1);
    for (k = 0; k < 40; k++) send_word(pick_sample(), 0);

    // sender pause until drained
    send_done();
    while (board.pending.size() != 0) @(posedge clk);

    no_idle = 1;
    for (k = 0; k < 150; k++) send_word(pick_sample(), k == 0);
    send_done();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
sv/rmh_pkg.sv
sv/rmh_datapath.sv
sv/rmh_ctrl.sv
sv/running_median_two_heaps_unit.sv
sv/rmh_checker.sv
tb/tb_running_median_two_heaps_unit.sv
